@@ rtl/ttrd_pkg.sv @@
`timescale 1ns / 1ps

package ttrd_pkg;

  localparam int unsigned CHAN_W  = 6;
  localparam int unsigned TIME_W  = 25;
  localparam int unsigned FINE_W  = 15;
  localparam int unsigned MACRO_W = 64;
  localparam int unsigned MICRO_W = 40;
  localparam int unsigned SYNC_W  = 30;
  localparam int unsigned TICK_W  = 26;
  localparam int unsigned WRAP_W  = 33;
  localparam int unsigned INC_W   = WRAP_W + TIME_W;
  localparam int unsigned CFG_W   = SYNC_W;
  localparam int unsigned IDX_W   = 2;

  // wrap constants per overflow count
  localparam logic [WRAP_W-1:0] T2_WRAP = WRAP_W'(33554432);
  localparam logic [WRAP_W-1:0] T3_WRAP = WRAP_W'(1024);

  localparam logic [CHAN_W-1:0] CH_OVERFLOW   = CHAN_W'(63);
  localparam logic [CHAN_W-1:0] CH_SYNC       = CHAN_W'(0);
  localparam logic [CHAN_W-1:0] CH_PHOTON_END = CHAN_W'(8);
  localparam logic [CHAN_W-1:0] CH_MARKER_MAX = CHAN_W'(15);

  localparam logic [IDX_W-1:0] REG_MODE_T3        = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SYNC_PERIOD_PS = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_PS_PER_TICK    = IDX_W'(2);

  localparam logic [SYNC_W-1:0] SYNC_PERIOD_RESET = SYNC_W'(12500);
  localparam logic [TICK_W-1:0] PS_PER_TICK_RESET = TICK_W'(1);

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_PHOTON = 2'd1;
  localparam logic [1:0] KIND_MARKER = 2'd2;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_CHANNEL  = 2'd1;
  localparam logic [1:0] ERR_ORDER    = 2'd2;
  localparam logic [1:0] ERR_SPECIAL  = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_PHOTON   = 2'd1,
    OP_MARKER   = 2'd2,
    OP_OVERFLOW = 2'd3
  } op_t;

  typedef struct packed {
    logic              special;
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] time_field;
    logic [FINE_W-1:0] fine_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CHAN_W-1:0]  event_channel;
    logic [MACRO_W-1:0] abs_time;
    logic [MICRO_W-1:0] micro_time;
    logic [1:0]         error_code;
  } out_item_t;

  typedef struct packed {
    logic              mode_t3;
    logic [SYNC_W-1:0] sync_period_ps;
    logic [TICK_W-1:0] ps_per_tick;
  } cfg_t;

  // classified record passed from front to back
  typedef struct packed {
    op_t                op;
    logic [1:0]         err;
    logic [CHAN_W-1:0]  chan;
    logic [TIME_W-1:0]  time_field;
    logic [INC_W-1:0]   inc;
    logic [MICRO_W-1:0] micro;
  } q_item_t;

endpackage

@@ rtl/ttrd_front.sv @@
`timescale 1ns / 1ps

module ttrd_front (
  input  logic              clk,
  input  logic              rst,
  input  ttrd_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  ttrd_pkg::in_item_t in_item,
  output logic              push,
  output ttrd_pkg::q_item_t push_item,
  input  logic              q_full
);

  localparam int unsigned MF_W = ttrd_pkg::FINE_W + ttrd_pkg::TICK_W;

  logic              f_valid;
  ttrd_pkg::q_item_t f_item;
  ttrd_pkg::q_item_t cls;
  logic [ttrd_pkg::WRAP_W-1:0]   wrap;
  logic [MF_W-1:0] micro_full;

  assign in_stall  = f_valid && q_full;
  assign push      = f_valid && !q_full;
  assign push_item = f_item;

  assign wrap       = cfg.mode_t3 ? ttrd_pkg::T3_WRAP : ttrd_pkg::T2_WRAP;
  assign micro_full = MF_W'(in_item.fine_time) * MF_W'(cfg.ps_per_tick);

  always_comb begin
    cls.op         = ttrd_pkg::OP_NONE;
    cls.err        = ttrd_pkg::ERR_OK;
    cls.chan       = in_item.channel;
    cls.time_field = in_item.time_field;
    cls.inc        = ttrd_pkg::INC_W'(in_item.time_field) * ttrd_pkg::INC_W'(wrap);
    cls.micro      = cfg.mode_t3 ? micro_full[ttrd_pkg::MICRO_W-1:0] : '0;
    if (!in_item.special) begin
      if (in_item.channel >= ttrd_pkg::CH_PHOTON_END) begin
        cls.err = ttrd_pkg::ERR_CHANNEL;
      end else begin
        cls.op = ttrd_pkg::OP_PHOTON;
      end
    end else if (in_item.channel == ttrd_pkg::CH_OVERFLOW) begin
      cls.op = ttrd_pkg::OP_OVERFLOW;
    end else if (in_item.channel == ttrd_pkg::CH_SYNC && !cfg.mode_t3) begin
      cls.op = ttrd_pkg::OP_NONE;
    end else if (in_item.channel != ttrd_pkg::CH_SYNC &&
                 in_item.channel <= ttrd_pkg::CH_MARKER_MAX) begin
      cls.op = ttrd_pkg::OP_MARKER;
    end else begin
      cls.err = ttrd_pkg::ERR_SPECIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      f_item <= cls;
    end
  end

  // an erroring record never carries an operation
  a_err_no_op: assert property (@(posedge clk) disable iff (rst)
    f_valid && f_item.err != ttrd_pkg::ERR_OK |-> f_item.op == ttrd_pkg::OP_NONE)
    else $error("classified record with error also carries an operation");

endmodule

@@ rtl/ttrd_queue.sv @@
`timescale 1ns / 1ps

module ttrd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ttrd_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ttrd_pkg::q_item_t head_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ttrd_pkg::q_item_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ rtl/ttrd_back.sv @@
`timescale 1ns / 1ps

module ttrd_back (
  input  logic               clk,
  input  logic               rst,
  input  ttrd_pkg::cfg_t     cfg,
  input  logic               head_valid,
  input  ttrd_pkg::q_item_t  head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ttrd_pkg::out_item_t out_item
);

  localparam int unsigned MW = ttrd_pkg::MACRO_W;
  localparam int unsigned PW = 32 + ttrd_pkg::SYNC_W;

  // running state
  logic [MW-1:0] overflow_sum;
  logic [MW-1:0] last_photon_time;
  logic [MW-1:0] last_marker_time;

  // stage 1: base time
  logic                        s1_valid;
  ttrd_pkg::op_t               s1_op;
  logic [1:0]                  s1_err;
  logic [ttrd_pkg::CHAN_W-1:0] s1_chan;
  logic [ttrd_pkg::MICRO_W-1:0] s1_micro;
  logic [MW-1:0]               s1_base;

  // stage 2: partial products
  logic                        s2_valid;
  ttrd_pkg::op_t               s2_op;
  logic [1:0]                  s2_err;
  logic [ttrd_pkg::CHAN_W-1:0] s2_chan;
  logic [ttrd_pkg::MICRO_W-1:0] s2_micro;
  logic [MW-1:0]               s2_base;
  logic [PW-1:0]               s2_prod_lo;
  logic [31:0]                 s2_prod_hi;

  logic s3_valid;
  logic s3_free;
  logic s2_free;
  logic s1_free;
  logic s2_adv;

  logic [PW-1:0] prod_lo;
  logic [PW-1:0] prod_hi_full;
  logic [MW-1:0] macro;
  logic          photon_ok;
  logic          marker_ok;
  ttrd_pkg::out_item_t res;

  assign s3_free = !s3_valid || !out_stall;
  assign s2_free = !s2_valid || s3_free;
  assign s1_free = !s1_valid || s2_free;
  assign s2_adv  = s2_valid && s3_free;
  assign pop     = head_valid && s1_free;

  assign out_valid = s3_valid;

  assign prod_lo      = PW'(s1_base[31:0]) * PW'(cfg.sync_period_ps);
  assign prod_hi_full = PW'(s1_base[MW-1:32]) * PW'(cfg.sync_period_ps);

  assign macro = cfg.mode_t3 ? (MW'(s2_prod_lo) + {s2_prod_hi, 32'b0}) : s2_base;

  assign photon_ok = (s2_op == ttrd_pkg::OP_PHOTON) && (macro >= last_photon_time);
  assign marker_ok = (s2_op == ttrd_pkg::OP_MARKER) && (macro >= last_marker_time);

  always_comb begin
    res = '0;
    res.error_code = s2_err;
    if (photon_ok) begin
      res.kind          = ttrd_pkg::KIND_PHOTON;
      res.event_channel = s2_chan;
      res.abs_time      = macro;
      res.micro_time    = s2_micro;
    end else if (marker_ok) begin
      res.kind          = ttrd_pkg::KIND_MARKER;
      res.event_channel = s2_chan;
      res.abs_time      = macro;
    end else if (s2_op == ttrd_pkg::OP_PHOTON || s2_op == ttrd_pkg::OP_MARKER) begin
      res.error_code = ttrd_pkg::ERR_ORDER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      s2_valid         <= 1'b0;
      s3_valid         <= 1'b0;
      overflow_sum     <= '0;
      last_photon_time <= '0;
      last_marker_time <= '0;
    end else begin
      if (s1_free) begin
        s1_valid <= pop;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
      if (pop && head_item.op == ttrd_pkg::OP_OVERFLOW) begin
        overflow_sum <= overflow_sum + MW'(head_item.inc);
      end
      if (s2_adv && photon_ok) begin
        last_photon_time <= macro;
      end
      if (s2_adv && marker_ok) begin
        last_marker_time <= macro;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op    <= head_item.op;
      s1_err   <= head_item.err;
      s1_chan  <= head_item.chan;
      s1_micro <= head_item.micro;
      // overflow count of earlier records only
      s1_base  <= overflow_sum + MW'(head_item.time_field);
    end
    if (s2_free && s1_valid) begin
      s2_op      <= s1_op;
      s2_err     <= s1_err;
      s2_chan    <= s1_chan;
      s2_micro   <= s1_micro;
      s2_base    <= s1_base;
      s2_prod_lo <= prod_lo;
      s2_prod_hi <= prod_hi_full[31:0];
    end
    if (s2_adv) begin
      out_item <= res;
    end
  end

  a_kind_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != ttrd_pkg::KIND_NONE |->
      out_item.error_code == ttrd_pkg::ERR_OK)
    else $error("reported event carries an error code");

  a_t2_micro_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cfg.mode_t3 |-> out_item.micro_time == '0)
    else $error("micro time reported in T2 mode");

  a_photon_order: assert property (@(posedge clk) disable iff (rst)
    s2_adv && photon_ok |=> last_photon_time >= $past(last_photon_time))
    else $error("photon time moved backward");

endmodule

@@ rtl/time_tag_record_decoder_core.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    in_item    (ttrd_pkg::in_item_t)
// out       output     out_valid / out_stall  out_item   (ttrd_pkg::out_item_t)
// cfg       input      cfg_write              cfg_index, cfg_data
//
// one record per cycle while out_stall is low; a taken record passes through the front
// register, queue, base-time add, partial products and compare into the output register
// overflow accumulation and the per-class order check each keep up with every record
// rst clears the pipeline, the queue and the running times and resets the config registers
// a stalled output holds the back end; the queue then fills and stalls the input

module time_tag_record_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ttrd_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ttrd_pkg::out_item_t        out_item,
  input  logic                       cfg_write,
  input  logic [ttrd_pkg::IDX_W-1:0] cfg_index,
  input  logic [ttrd_pkg::CFG_W-1:0] cfg_data
);

  ttrd_pkg::cfg_t    cfg;
  logic              push;
  ttrd_pkg::q_item_t push_item;
  logic              q_full;
  logic              pop;
  logic              head_valid;
  ttrd_pkg::q_item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_t3        <= 1'b0;
      cfg.sync_period_ps <= ttrd_pkg::SYNC_PERIOD_RESET;
      cfg.ps_per_tick    <= ttrd_pkg::PS_PER_TICK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ttrd_pkg::REG_MODE_T3:        cfg.mode_t3        <= cfg_data[0];
        ttrd_pkg::REG_SYNC_PERIOD_PS: cfg.sync_period_ps <= cfg_data[ttrd_pkg::SYNC_W-1:0];
        ttrd_pkg::REG_PS_PER_TICK:    cfg.ps_per_tick    <= cfg_data[ttrd_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  ttrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  ttrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ttrd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

@@ test/time_tag_record_decoder_core_tb.sv @@
`timescale 1ns / 1ps

module time_tag_record_decoder_core_tb;

  localparam logic MODE_T2 = 1'b0;
  localparam logic MODE_T3 = 1'b1;
  localparam logic [ttrd_pkg::TIME_W-1:0] TF_MAX   = {ttrd_pkg::TIME_W{1'b1}};
  localparam logic [ttrd_pkg::FINE_W-1:0] FINE_MAX = {ttrd_pkg::FINE_W{1'b1}};
  localparam logic [ttrd_pkg::SYNC_W-1:0] SYNC_MAX = {ttrd_pkg::SYNC_W{1'b1}};
  localparam logic [ttrd_pkg::TICK_W-1:0] TICK_MAX = {ttrd_pkg::TICK_W{1'b1}};
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 10;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  ttrd_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  ttrd_pkg::out_item_t out_item;
  logic cfg_write;
  logic [ttrd_pkg::IDX_W-1:0] cfg_index;
  logic [ttrd_pkg::CFG_W-1:0] cfg_data;

  // decoder state and register copies
  logic cfg_t3;
  logic [ttrd_pkg::SYNC_W-1:0] cfg_sync;
  logic [ttrd_pkg::TICK_W-1:0] cfg_tick;
  logic [63:0] ovf_sum;
  logic [63:0] last_photon_time;
  logic [63:0] last_marker_time;

  // stimulus state
  logic [63:0] tf_cursor;
  int unsigned tf_step;
  bit idle_en = 1'b1;
  bit hold_off_request = 1'b0;

  ttrd_pkg::out_item_t pending_events[$];
  ttrd_pkg::out_item_t oldest_event;
  int mismatch_count = 0;

  time_tag_record_decoder_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic ttrd_pkg::in_item_t make_record(input logic special,
                                                     input logic [ttrd_pkg::CHAN_W-1:0] chan,
                                                     input logic [ttrd_pkg::TIME_W-1:0] tf,
                                                     input logic [ttrd_pkg::FINE_W-1:0] fine);
    ttrd_pkg::in_item_t rec;
    rec.special = special;
    rec.channel = chan;
    rec.time_field = tf;
    rec.fine_time = fine;
    return rec;
  endfunction

  // computes the event for one record and advances the running times
  function automatic ttrd_pkg::out_item_t decode_record(input ttrd_pkg::in_item_t rec);
    ttrd_pkg::out_item_t ev;
    logic [63:0] base;
    logic [63:0] macro;
    logic [63:0] micro_full;
    logic [63:0] wrap;
    ev = '0;
    base = ovf_sum + 64'(rec.time_field);
    macro = cfg_t3 ? base * 64'(cfg_sync) : base;
    wrap = cfg_t3 ? 64'(ttrd_pkg::T3_WRAP) : 64'(ttrd_pkg::T2_WRAP);
    if (!rec.special) begin
      if (rec.channel >= ttrd_pkg::CH_PHOTON_END) begin
        ev.error_code = ttrd_pkg::ERR_CHANNEL;
      end else if (macro < last_photon_time) begin
        ev.error_code = ttrd_pkg::ERR_ORDER;
      end else begin
        last_photon_time = macro;
        micro_full = 64'(cfg_tick) * 64'(rec.fine_time);
        ev.kind = ttrd_pkg::KIND_PHOTON;
        ev.event_channel = rec.channel;
        ev.abs_time = macro;
        ev.micro_time = cfg_t3 ? micro_full[ttrd_pkg::MICRO_W-1:0] : '0;
      end
    end else if (rec.channel == ttrd_pkg::CH_OVERFLOW) begin
      ovf_sum = ovf_sum + wrap * 64'(rec.time_field);
    end else if (rec.channel == ttrd_pkg::CH_SYNC && !cfg_t3) begin
      ev = '0;
    end else if (rec.channel != ttrd_pkg::CH_SYNC && rec.channel <= ttrd_pkg::CH_MARKER_MAX) begin
      if (macro < last_marker_time) begin
        ev.error_code = ttrd_pkg::ERR_ORDER;
      end else begin
        last_marker_time = macro;
        ev.kind = ttrd_pkg::KIND_MARKER;
        ev.event_channel = rec.channel;
        ev.abs_time = macro;
      end
    end else begin
      ev.error_code = ttrd_pkg::ERR_SPECIAL;
    end
    return ev;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("item with no event waiting: kind %0d, abs_time 0x%0h", out_item.kind,
               out_item.abs_time);
        mismatch_count++;
      end else begin
        oldest_event = pending_events.pop_front();
        check_field("kind", 64'(oldest_event.kind), 64'(out_item.kind));
        check_field("event_channel", 64'(oldest_event.event_channel),
                    64'(out_item.event_channel));
        check_field("abs_time", oldest_event.abs_time, out_item.abs_time);
        check_field("micro_time", 64'(oldest_event.micro_time), 64'(out_item.micro_time));
        check_field("error_code", 64'(oldest_event.error_code), 64'(out_item.error_code));
      end
    end
  end

  // output side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_off_request = 1'b0;
      end else if (idle_en && $urandom_range(15) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(17, 1)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // entered and left at a falling edge; valid stays high for a following item
  task automatic send_record(input ttrd_pkg::in_item_t rec);
    if (idle_en && $urandom_range(5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= rec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_events.push_back(decode_record(rec));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(input logic mode, input logic [ttrd_pkg::SYNC_W-1:0] sync,
                             input logic [ttrd_pkg::TICK_W-1:0] tick);
    cfg_write <= 1'b1;
    cfg_index <= ttrd_pkg::REG_MODE_T3;
    cfg_data <= ttrd_pkg::CFG_W'(mode);
    @(negedge clk);
    cfg_index <= ttrd_pkg::REG_SYNC_PERIOD_PS;
    cfg_data <= ttrd_pkg::CFG_W'(sync);
    @(negedge clk);
    cfg_index <= ttrd_pkg::REG_PS_PER_TICK;
    cfg_data <= ttrd_pkg::CFG_W'(tick);
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_t3 = mode;
    cfg_sync = sync;
    cfg_tick = tick;
    tf_step = mode ? 4096 : (1 << 20);
    tf_cursor = '0;
  endtask

  // mostly ordered photon/marker streams with overflows, the rest noise
  task automatic run_random(input int count);
    ttrd_pkg::in_item_t rec;
    logic [63:0] top;
    logic [63:0] need;
    logic [63:0] diff;
    logic [63:0] wrap;
    int unsigned back;
    int i;
    int k;
    int pick;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      wrap = cfg_t3 ? 64'(ttrd_pkg::T3_WRAP) : 64'(ttrd_pkg::T2_WRAP);
      rec = '0;
      rec.fine_time = ttrd_pkg::FINE_W'($urandom);
      if (pick < 72) begin
        tf_cursor = tf_cursor + 64'($urandom_range(tf_step));
        if (tf_cursor > 64'(TF_MAX) || pick < 4) begin
          send_record(make_record(1'b1, ttrd_pkg::CH_OVERFLOW, 25'd1,
                                  ttrd_pkg::FINE_W'($urandom)));
          tf_cursor = (tf_cursor >= wrap) ? tf_cursor - wrap : '0;
        end
        // lift the cursor so the next time is not behind either running time
        for (k = 0; k < 4; k++) begin
          top = (last_photon_time > last_marker_time) ? last_photon_time : last_marker_time;
          if (!cfg_t3) need = top;
          else if (cfg_sync == 0) need = '0;
          else need = top / 64'(cfg_sync) + 64'((top % 64'(cfg_sync)) != 0);
          if (need <= ovf_sum + tf_cursor) break;
          diff = need - ovf_sum;
          if (diff <= 64'(TF_MAX)) begin
            tf_cursor = diff;
            break;
          end
          send_record(make_record(1'b1, ttrd_pkg::CH_OVERFLOW,
                                  (diff / wrap >= 64'(TF_MAX)) ? TF_MAX
                                      : ttrd_pkg::TIME_W'(diff / wrap + 64'd1),
                                  ttrd_pkg::FINE_W'($urandom)));
          tf_cursor = '0;
        end
        if (pick < 43) begin
          rec.special = 1'b0;
          rec.channel = ttrd_pkg::CHAN_W'($urandom_range(ttrd_pkg::CH_PHOTON_END - 6'd1));
        end else begin
          rec.special = 1'b1;
          rec.channel = ttrd_pkg::CHAN_W'($urandom_range(ttrd_pkg::CH_MARKER_MAX, 1));
        end
        rec.time_field = tf_cursor[ttrd_pkg::TIME_W-1:0];
      end else begin
        case ($urandom_range(5))
          0: begin
            rec.special = 1'($urandom);
            rec.channel = ttrd_pkg::CHAN_W'($urandom);
            rec.time_field = ttrd_pkg::TIME_W'($urandom);
          end
          1: begin
            rec.channel = ttrd_pkg::CHAN_W'($urandom_range(ttrd_pkg::CH_OVERFLOW,
                                                           ttrd_pkg::CH_PHOTON_END));
            rec.time_field = tf_cursor[ttrd_pkg::TIME_W-1:0];
          end
          2: begin
            back = $urandom_range(1000, 1);
            rec.special = 1'($urandom);
            rec.channel = rec.special
                ? ttrd_pkg::CHAN_W'($urandom_range(ttrd_pkg::CH_MARKER_MAX, 1))
                : ttrd_pkg::CHAN_W'($urandom_range(ttrd_pkg::CH_PHOTON_END - 6'd1));
            rec.time_field = (tf_cursor > 64'(back))
                ? ttrd_pkg::TIME_W'(tf_cursor - 64'(back)) : '0;
          end
          3: begin
            rec.special = 1'b1;
            rec.channel = ttrd_pkg::CHAN_W'($urandom_range(ttrd_pkg::CH_OVERFLOW - 6'd1,
                                                           ttrd_pkg::CH_MARKER_MAX + 6'd1));
            rec.time_field = ttrd_pkg::TIME_W'($urandom);
          end
          4: begin
            rec.special = 1'b1;
            rec.channel = ttrd_pkg::CH_SYNC;
            rec.time_field = tf_cursor[ttrd_pkg::TIME_W-1:0];
          end
          default: begin
            rec.special = 1'b1;
            rec.channel = ttrd_pkg::CH_OVERFLOW;
            rec.time_field = ttrd_pkg::TIME_W'($urandom_range(3));
          end
        endcase
      end
      send_record(rec);
    end
  endtask

  task automatic test_zero_registers();
    load_config(MODE_T3, '0, '0);
    send_record(make_record(1'b0, 6'd3, TF_MAX, FINE_MAX));
    send_record(make_record(1'b1, ttrd_pkg::CH_MARKER_MAX, 25'd12345, 15'd0));
    send_record(make_record(1'b1, ttrd_pkg::CH_OVERFLOW, 25'd5, 15'd0));
    send_record(make_record(1'b0, 6'd7, 25'd1, FINE_MAX));
    wait_idle();
  endtask

  task automatic test_t2_records();
    load_config(MODE_T2, ttrd_pkg::SYNC_PERIOD_RESET, ttrd_pkg::PS_PER_TICK_RESET);
    send_record(make_record(1'b1, ttrd_pkg::CH_SYNC, 25'd777, 15'd3));
    send_record(make_record(1'b0, 6'd0, 25'd100, FINE_MAX));
    send_record(make_record(1'b0, 6'd7, 25'd100, 15'd0));
    send_record(make_record(1'b0, 6'd1, 25'd99, 15'd0));
    send_record(make_record(1'b0, ttrd_pkg::CH_PHOTON_END, 25'd200, 15'd0));
    send_record(make_record(1'b0, ttrd_pkg::CH_OVERFLOW, 25'd200, 15'd0));
    send_record(make_record(1'b1, 6'd1, 25'd50, 15'd0));
    send_record(make_record(1'b1, ttrd_pkg::CH_MARKER_MAX, 25'd40, 15'd0));
    send_record(make_record(1'b1, ttrd_pkg::CH_MARKER_MAX + 6'd1, 25'd0, 15'd0));
    send_record(make_record(1'b1, ttrd_pkg::CH_OVERFLOW - 6'd1, TF_MAX, FINE_MAX));
    send_record(make_record(1'b1, ttrd_pkg::CH_OVERFLOW, 25'd1, 15'd0));
    send_record(make_record(1'b0, 6'd5, 25'd0, 15'd0));
    send_record(make_record(1'b0, 6'd6, TF_MAX, 15'd0));
    send_record(make_record(1'b1, ttrd_pkg::CH_OVERFLOW, 25'd0, 15'd0));
    wait_idle();
  endtask

  task automatic test_t3_records();
    load_config(MODE_T3, 30'd1, TICK_MAX);
    send_record(make_record(1'b1, ttrd_pkg::CH_SYNC, 25'd5, 15'd0));
    send_record(make_record(1'b0, 6'd2, TF_MAX, FINE_MAX));
    send_record(make_record(1'b1, 6'd9, TF_MAX, FINE_MAX));
    send_record(make_record(1'b1, ttrd_pkg::CH_OVERFLOW, 25'd2, 15'd0));
    send_record(make_record(1'b0, 6'd4, TF_MAX, 15'd0));
    wait_idle();
  endtask

  task automatic test_random_t2();
    load_config(MODE_T2, ttrd_pkg::SYNC_PERIOD_RESET, ttrd_pkg::PS_PER_TICK_RESET);
    run_random(300);
    wait_idle();
  endtask

  task automatic test_random_t2_unused_regs();
    load_config(MODE_T2, ttrd_pkg::SYNC_W'($urandom), ttrd_pkg::TICK_W'($urandom));
    run_random(200);
    wait_idle();
  endtask

  task automatic test_backpressure();
    load_config(MODE_T2, SYNC_MAX, TICK_MAX);
    hold_off_request = 1'b1;
    run_random(150);
    wait_idle();
  endtask

  task automatic test_random_t3_unit();
    load_config(MODE_T3, 30'd1, 26'd1);
    run_random(200);
    wait_idle();
  endtask

  task automatic test_random_t3_default_period();
    load_config(MODE_T3, ttrd_pkg::SYNC_PERIOD_RESET,
                ttrd_pkg::TICK_W'($urandom_range(1 << 25, 1)));
    run_random(250);
    wait_idle();
  endtask

  task automatic test_random_t3_wide_period();
    load_config(MODE_T3, ttrd_pkg::SYNC_W'($urandom_range(1000000000, 12500)),
                ttrd_pkg::TICK_W'($urandom));
    run_random(250);
    wait_idle();
  endtask

  // largest registers, no idling; a full overflow count then wraps the macro time
  task automatic test_max_registers();
    idle_en = 1'b0;
    load_config(MODE_T3, SYNC_MAX, TICK_MAX);
    run_random(220);
    send_record(make_record(1'b1, ttrd_pkg::CH_OVERFLOW, TF_MAX, FINE_MAX));
    run_random(30);
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_t3 = MODE_T2;
    cfg_sync = ttrd_pkg::SYNC_PERIOD_RESET;
    cfg_tick = ttrd_pkg::PS_PER_TICK_RESET;
    ovf_sum = '0;
    last_photon_time = '0;
    last_marker_time = '0;
    tf_cursor = '0;
    tf_step = 1 << 20;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_zero_registers();
    test_t2_records();
    test_t3_records();
    test_random_t2();
    test_random_t2_unused_regs();
    test_backpressure();
    test_random_t3_unit();
    test_random_t3_default_period();
    test_random_t3_wide_period();
    test_max_registers();
    if (mismatch_count == 0) begin
      $display("time_tag_record_decoder_core_tb: PASS");
    end else begin
      $display("time_tag_record_decoder_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("time_tag_record_decoder_core_tb: FAIL");
    $finish;
  end

endmodule
